>>> src/assert_macros.svh
// Assertion macros shared by the verification code of the collision test block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define SPCT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("collision test assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define SPCT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("collision test assertion failed");

`endif

>>> src/spct_pkg.sv
// Package: request and result types, type codes and pipeline control for the collision test.
package spct_pkg;

	// Shape type codes
	localparam logic [1:0] TYPE_BOX    = 2'd0;
	localparam logic [1:0] TYPE_CIRCLE = 2'd1;

	// One request: two shapes
	typedef struct packed {
		logic [1:0]         first_type;
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic [14:0]        first_width;
		logic [14:0]        first_height;
		logic [14:0]        first_radius;
		logic [1:0]         second_type;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
		logic [14:0]        second_width;
		logic [14:0]        second_height;
		logic [14:0]        second_radius;
	} pair_t;

	// One result
	typedef struct packed {
		logic hit;
		logic status;
	} verdict_t;

	// Kind of pair being tested
	typedef enum logic [1:0] {
		KIND_BOX_BOX,
		KIND_CIRC_CIRC,
		KIND_CIRC_BOX,
		KIND_BAD
	} kind_t;

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

endpackage

>>> src/shape_pair_collision_test_unit.sv
// Top level: five-stage box and circle collision test pipeline with stall control.
//
// Tests one pair of 2D shapes (box or circle each) per request and returns a
// hit flag and a status flag (status 1 for an unsupported type). The pipeline
// takes one request per clock while the result side does not stall; the depth
// is set by the decode, the clamp, the difference, the squaring multipliers
// and the final add and compare, each in its own stage. A stall on the result
// side holds the last stage; empty stages in front of it keep filling, and the
// request side stalls only when all five stages are full and the result is held.
// Coordinates use the low COORD_BITS bits of each position field as two's
// complement; all arithmetic is exact.
module shape_pair_collision_test_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pair_valid,
	output logic                 pair_stall,
	input  spct_pkg::pair_t      pair,
	output logic                 verdict_valid,
	input  logic                 verdict_stall,
	output spct_pkg::verdict_t   verdict
);

	localparam int CW = COORD_BITS;

	spct_pkg::adv_t          adv;
	logic                    v_s1, v_s2, v_s3, v_s4, v_s5;
	spct_pkg::kind_t         kind_s1, kind_s3;
	logic signed [CW:0]      cx_s1, cy_s1, bxl_s1, bxh_s1, byl_s1, byh_s1;
	logic signed [CW:0]      axl_s1, axh_s1, ayl_s1, ayh_s1;
	logic [CW-1:0]           r_s1, r_s3;
	logic                    bb_s3;
	logic [CW:0]             magx_s3, magy_s3;

	// A stage loads when it is empty or its successor loads
	always_comb begin
		adv.s5 = !v_s5 || !verdict_stall;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign pair_stall    = !adv.s1;
	assign verdict_valid = v_s5;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= pair_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
		end
	end

	spct_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk     (clk),
		.en      (adv.s1),
		.pair    (pair),
		.kind_s1 (kind_s1),
		.cx_s1   (cx_s1),
		.cy_s1   (cy_s1),
		.bxl_s1  (bxl_s1),
		.bxh_s1  (bxh_s1),
		.byl_s1  (byl_s1),
		.byh_s1  (byh_s1),
		.axl_s1  (axl_s1),
		.axh_s1  (axh_s1),
		.ayl_s1  (ayl_s1),
		.ayh_s1  (ayh_s1),
		.r_s1    (r_s1)
	);

	spct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp (
		.clk     (clk),
		.adv     (adv),
		.kind_s1 (kind_s1),
		.cx_s1   (cx_s1),
		.cy_s1   (cy_s1),
		.bxl_s1  (bxl_s1),
		.bxh_s1  (bxh_s1),
		.byl_s1  (byl_s1),
		.byh_s1  (byh_s1),
		.axl_s1  (axl_s1),
		.axh_s1  (axh_s1),
		.ayl_s1  (ayl_s1),
		.ayh_s1  (ayh_s1),
		.r_s1    (r_s1),
		.kind_s3 (kind_s3),
		.bb_s3   (bb_s3),
		.magx_s3 (magx_s3),
		.magy_s3 (magy_s3),
		.r_s3    (r_s3)
	);

	spct_dist #(.COORD_BITS(COORD_BITS)) u_dist (
		.clk        (clk),
		.adv        (adv),
		.kind_s3    (kind_s3),
		.bb_s3      (bb_s3),
		.magx_s3    (magx_s3),
		.magy_s3    (magy_s3),
		.r_s3       (r_s3),
		.verdict_s5 (verdict)
	);

endmodule

>>> src/spct_prep.sv
// Stage 1: decode the request, assign circle and box roles, form box edges.
module spct_prep #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  spct_pkg::pair_t               pair,
	output spct_pkg::kind_t               kind_s1,
	output logic signed [COORD_BITS:0]    cx_s1,
	output logic signed [COORD_BITS:0]    cy_s1,
	output logic signed [COORD_BITS:0]    bxl_s1,
	output logic signed [COORD_BITS:0]    bxh_s1,
	output logic signed [COORD_BITS:0]    byl_s1,
	output logic signed [COORD_BITS:0]    byh_s1,
	output logic signed [COORD_BITS:0]    axl_s1,
	output logic signed [COORD_BITS:0]    axh_s1,
	output logic signed [COORD_BITS:0]    ayl_s1,
	output logic signed [COORD_BITS:0]    ayh_s1,
	output logic [COORD_BITS-1:0]         r_s1
);

	localparam int CW    = COORD_BITS;
	localparam int EW    = COORD_BITS + 1;
	localparam int IBITS = (CW < 16) ? CW : 16;
	localparam int SBITS = ((CW - 1) < 15) ? (CW - 1) : 15;

	logic [CW-1:0]         x1_raw, y1_raw, x2_raw, y2_raw;
	logic signed [EW-1:0]  x1, y1, x2, y2;
	logic [CW-2:0]         w1, h1, r1, w2, h2, r2;
	logic                  circ_first, box_first;
	spct_pkg::kind_t       kind;
	logic signed [EW-1:0]  box_x, box_y, size_w, size_h;
	logic [CW-1:0]         r;

	// Low coordinate bits as two's complement, size fields as unsigned
	assign x1_raw = CW'(pair.first_x[IBITS-1:0]);
	assign y1_raw = CW'(pair.first_y[IBITS-1:0]);
	assign x2_raw = CW'(pair.second_x[IBITS-1:0]);
	assign y2_raw = CW'(pair.second_y[IBITS-1:0]);
	assign x1 = $signed({x1_raw[CW-1], x1_raw});
	assign y1 = $signed({y1_raw[CW-1], y1_raw});
	assign x2 = $signed({x2_raw[CW-1], x2_raw});
	assign y2 = $signed({y2_raw[CW-1], y2_raw});
	assign w1 = (CW-1)'(pair.first_width[SBITS-1:0]);
	assign h1 = (CW-1)'(pair.first_height[SBITS-1:0]);
	assign r1 = (CW-1)'(pair.first_radius[SBITS-1:0]);
	assign w2 = (CW-1)'(pair.second_width[SBITS-1:0]);
	assign h2 = (CW-1)'(pair.second_height[SBITS-1:0]);
	assign r2 = (CW-1)'(pair.second_radius[SBITS-1:0]);

	// Pair kind and role selection; a circle pair becomes a circle against
	// a zero-size box at the other center with the summed radius
	always_comb begin
		circ_first = (pair.first_type == spct_pkg::TYPE_CIRCLE);
		if ((pair.first_type != spct_pkg::TYPE_BOX && pair.first_type != spct_pkg::TYPE_CIRCLE)
		    || (pair.second_type != spct_pkg::TYPE_BOX
		    && pair.second_type != spct_pkg::TYPE_CIRCLE))
			kind = spct_pkg::KIND_BAD;
		else if (pair.first_type == spct_pkg::TYPE_BOX && pair.second_type == spct_pkg::TYPE_BOX)
			kind = spct_pkg::KIND_BOX_BOX;
		else if (circ_first && pair.second_type == spct_pkg::TYPE_CIRCLE)
			kind = spct_pkg::KIND_CIRC_CIRC;
		else
			kind = spct_pkg::KIND_CIRC_BOX;
		box_first = (kind == spct_pkg::KIND_CIRC_BOX) && !circ_first;

		box_x  = box_first ? x1 : x2;
		box_y  = box_first ? y1 : y2;
		size_w = $signed({2'b00, (box_first ? w1 : w2)});
		size_h = $signed({2'b00, (box_first ? h1 : h2)});
		if (kind == spct_pkg::KIND_CIRC_CIRC) begin
			size_w = '0;
			size_h = '0;
		end

		if (kind == spct_pkg::KIND_CIRC_CIRC)
			r = {1'b0, r1} + {1'b0, r2};
		else
			r = {1'b0, (circ_first ? r1 : r2)};
	end

	// Stage 1 registers
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			cx_s1   <= circ_first ? x1 : x2;
			cy_s1   <= circ_first ? y1 : y2;
			bxl_s1  <= box_x;
			bxh_s1  <= box_x + size_w;
			byl_s1  <= box_y;
			byh_s1  <= box_y + size_h;
			axl_s1  <= x1;
			axh_s1  <= x1 + $signed({2'b00, w1});
			ayl_s1  <= y1;
			ayh_s1  <= y1 + $signed({2'b00, h1});
			r_s1    <= r;
		end
	end

endmodule

>>> src/spct_clamp.sv
// Stages 2 and 3: clamp the circle center into the box, box overlap, distance magnitudes.
module spct_clamp #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  spct_pkg::adv_t                adv,
	input  spct_pkg::kind_t               kind_s1,
	input  logic signed [COORD_BITS:0]    cx_s1,
	input  logic signed [COORD_BITS:0]    cy_s1,
	input  logic signed [COORD_BITS:0]    bxl_s1,
	input  logic signed [COORD_BITS:0]    bxh_s1,
	input  logic signed [COORD_BITS:0]    byl_s1,
	input  logic signed [COORD_BITS:0]    byh_s1,
	input  logic signed [COORD_BITS:0]    axl_s1,
	input  logic signed [COORD_BITS:0]    axh_s1,
	input  logic signed [COORD_BITS:0]    ayl_s1,
	input  logic signed [COORD_BITS:0]    ayh_s1,
	input  logic [COORD_BITS-1:0]         r_s1,
	output spct_pkg::kind_t               kind_s3,
	output logic                          bb_s3,
	output logic [COORD_BITS:0]           magx_s3,
	output logic [COORD_BITS:0]           magy_s3,
	output logic [COORD_BITS-1:0]         r_s3
);

	localparam int EW = COORD_BITS + 1;

	logic                  ltx, gtx, lty, gty, bb;
	logic signed [EW-1:0]  px, py;
	spct_pkg::kind_t       kind_s2;
	logic                  bb_s2, ltx_s2, lty_s2;
	logic signed [EW-1:0]  px_s2, py_s2, cx_s2, cy_s2;
	logic [COORD_BITS-1:0] r_s2;
	logic signed [EW:0]    dxp, dxn, dyp, dyn;

	// Clamp and strict box interval overlap
	always_comb begin
		ltx = cx_s1 < bxl_s1;
		gtx = cx_s1 > bxh_s1;
		lty = cy_s1 < byl_s1;
		gty = cy_s1 > byh_s1;
		px  = ltx ? bxl_s1 : (gtx ? bxh_s1 : cx_s1);
		py  = lty ? byl_s1 : (gty ? byh_s1 : cy_s1);
		bb  = (axl_s1 < bxh_s1) && (axh_s1 > bxl_s1) && (ayl_s1 < byh_s1) && (ayh_s1 > byl_s1);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			kind_s2 <= kind_s1;
			bb_s2   <= bb;
			ltx_s2  <= ltx;
			lty_s2  <= lty;
			px_s2   <= px;
			py_s2   <= py;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			r_s2    <= r_s1;
		end
	end

	// Both difference directions; the clamp side picks the non-negative one
	assign dxp = {px_s2[EW-1], px_s2} - {cx_s2[EW-1], cx_s2};
	assign dxn = {cx_s2[EW-1], cx_s2} - {px_s2[EW-1], px_s2};
	assign dyp = {py_s2[EW-1], py_s2} - {cy_s2[EW-1], cy_s2};
	assign dyn = {cy_s2[EW-1], cy_s2} - {py_s2[EW-1], py_s2};

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			kind_s3 <= kind_s2;
			bb_s3   <= bb_s2;
			magx_s3 <= ltx_s2 ? dxp[EW-1:0] : dxn[EW-1:0];
			magy_s3 <= lty_s2 ? dyp[EW-1:0] : dyn[EW-1:0];
			r_s3    <= r_s2;
		end
	end

endmodule

>>> src/spct_dist.sv
// Stages 4 and 5: exact squares, distance sum against squared radius, result.
module spct_dist #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  spct_pkg::adv_t          adv,
	input  spct_pkg::kind_t         kind_s3,
	input  logic                    bb_s3,
	input  logic [COORD_BITS:0]     magx_s3,
	input  logic [COORD_BITS:0]     magy_s3,
	input  logic [COORD_BITS-1:0]   r_s3,
	output spct_pkg::verdict_t      verdict_s5
);

	localparam int EW = COORD_BITS + 1;
	localparam int QW = 2 * EW;
	localparam int RW = 2 * COORD_BITS;
	localparam int SW = QW + 1;

	spct_pkg::kind_t kind_s4;
	logic            bb_s4;
	logic [QW-1:0]   sqx_s4, sqy_s4;
	logic [RW-1:0]   rr_s4;
	logic [SW-1:0]   dsum;
	logic            in_reach;
	spct_pkg::verdict_t verdict;

	// Squares, one multiplier each
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			kind_s4 <= kind_s3;
			bb_s4   <= bb_s3;
			sqx_s4  <= QW'(magx_s3) * QW'(magx_s3);
			sqy_s4  <= QW'(magy_s3) * QW'(magy_s3);
			rr_s4   <= RW'(r_s3) * RW'(r_s3);
		end
	end

	// Touching counts for circle tests
	assign dsum     = SW'(sqx_s4) + SW'(sqy_s4);
	assign in_reach = dsum <= SW'(rr_s4);

	always_comb begin
		unique case (kind_s4)
			spct_pkg::KIND_BOX_BOX:   verdict = '{hit: bb_s4, status: 1'b0};
			spct_pkg::KIND_CIRC_CIRC,
			spct_pkg::KIND_CIRC_BOX:  verdict = '{hit: in_reach, status: 1'b0};
			default:                  verdict = '{hit: 1'b0, status: 1'b1};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s5)
			verdict_s5 <= verdict;
	end

endmodule

>>> src/spct_checker.sv
// Port-level checker for the collision test block, bound to the top level.
`include "assert_macros.svh"

module spct_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pair_valid,
	input logic               pair_stall,
	input logic               verdict_valid,
	input logic               verdict_stall,
	input spct_pkg::verdict_t verdict
);

	// An unsupported pair never reports a hit
	`SPCT_ASSERT_IMPL(a_status_no_hit, clk, arst_n, verdict_valid, !(verdict.hit && verdict.status))

	// Requests back up only behind a held result
	`SPCT_ASSERT_IMPL(a_stall_source, clk, arst_n, pair_stall, verdict_valid && verdict_stall)

	// A held result stays put
	`SPCT_ASSERT_NEXT(a_hold, clk, arst_n, verdict_valid && verdict_stall, verdict_valid && $stable(verdict))

	// A result after an idle stretch on the result side must come from a request accepted a full pipeline depth back
	`SPCT_ASSERT_IMPL(a_latency, clk, arst_n, verdict_valid && !$past(verdict_valid) && !$past(verdict_valid, 2) && !$past(verdict_valid, 3) && !$past(verdict_valid, 4), $past(pair_valid && !pair_stall, 5))

endmodule

bind shape_pair_collision_test_unit spct_checker u_spct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pair_valid    (pair_valid),
	.pair_stall    (pair_stall),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict       (verdict)
);

>>> verif/shape_pair_collision_test_unit_test.sv
// Self-checking testbench for the shape pair collision test unit.
`timescale 1ns / 1ps

module shape_pair_collision_test_unit_test;

	localparam logic [1:0] TYPE_UNSUPPORTED = 2'd2;
	localparam logic [1:0] TYPE_RESERVED    = 2'd3;
	localparam int         CYCLE_LIMIT      = 300000;
	localparam int         LONG_HOLD_CYCLES = 100;
	localparam int         SHOWN_MISMATCHES = 10;

	// Expected verdicts in request order, plus the overlap predictor
	class overlap_tracker;
		spct_pkg::verdict_t expected_verdicts[$];
		int                 mismatch_count;
		int                 verdict_index;

		static function bit circle_touches_box(longint cx, longint cy, longint r,
				longint bx, longint by, longint bw, longint bh);
			longint px;
			longint py;
			// nearest point of the box to the circle center
			px = (cx < bx) ? bx : ((cx > bx + bw) ? bx + bw : cx);
			py = (cy < by) ? by : ((cy > by + bh) ? by + bh : cy);
			return (px - cx) * (px - cx) + (py - cy) * (py - cy) <= r * r;
		endfunction

		static function spct_pkg::verdict_t predict_overlap(spct_pkg::pair_t p);
			longint             x1, y1, w1, h1, r1;
			longint             x2, y2, w2, h2, r2;
			spct_pkg::kind_t    kind;
			spct_pkg::verdict_t v;
			x1 = longint'($signed(p.first_x));
			y1 = longint'($signed(p.first_y));
			w1 = longint'(p.first_width);
			h1 = longint'(p.first_height);
			r1 = longint'(p.first_radius);
			x2 = longint'($signed(p.second_x));
			y2 = longint'($signed(p.second_y));
			w2 = longint'(p.second_width);
			h2 = longint'(p.second_height);
			r2 = longint'(p.second_radius);
			if (p.first_type > spct_pkg::TYPE_CIRCLE || p.second_type > spct_pkg::TYPE_CIRCLE)
				kind = spct_pkg::KIND_BAD;
			else if (p.first_type == spct_pkg::TYPE_BOX && p.second_type == spct_pkg::TYPE_BOX)
				kind = spct_pkg::KIND_BOX_BOX;
			else if (p.first_type == spct_pkg::TYPE_CIRCLE
			    && p.second_type == spct_pkg::TYPE_CIRCLE)
				kind = spct_pkg::KIND_CIRC_CIRC;
			else
				kind = spct_pkg::KIND_CIRC_BOX;
			v.status = (kind == spct_pkg::KIND_BAD);
			case (kind)
				spct_pkg::KIND_BOX_BOX: begin
					// strict: shared edges are not an overlap
					v.hit = (x1 < x2 + w2) && (x1 + w1 > x2) && (y1 < y2 + h2) && (y1 + h1 > y2);
				end
				spct_pkg::KIND_CIRC_CIRC: begin
					v.hit = (x1 - x2) * (x1 - x2) + (y1 - y2) * (y1 - y2)
						<= (r1 + r2) * (r1 + r2);
				end
				spct_pkg::KIND_CIRC_BOX: begin
					if (p.first_type == spct_pkg::TYPE_CIRCLE)
						v.hit = circle_touches_box(x1, y1, r1, x2, y2, w2, h2);
					else
						v.hit = circle_touches_box(x2, y2, r2, x1, y1, w1, h1);
				end
				default: begin
					v.hit = 1'b0;
				end
			endcase
			return v;
		endfunction

		function void note_pair(spct_pkg::pair_t p);
			expected_verdicts.push_back(predict_overlap(p));
		endfunction

		function void flag(string what, logic want, logic got);
			mismatch_count++;
			if (mismatch_count <= SHOWN_MISMATCHES)
				$display("mismatch on verdict %0d, %s: expected %b, got %b",
					verdict_index, what, want, got);
		endfunction

		function void check_verdict(spct_pkg::verdict_t got);
			spct_pkg::verdict_t want;
			if (expected_verdicts.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_MISMATCHES)
					$display("verdict with no request pending: hit %b status %b",
						got.hit, got.status);
				return;
			end
			want = expected_verdicts.pop_front();
			if (got.hit !== want.hit)
				flag("hit", want.hit, got.hit);
			if (got.status !== want.status)
				flag("status", want.status, got.status);
			verdict_index++;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               pair_valid = 1'b0;
	logic               pair_stall;
	spct_pkg::pair_t    pair = '0;
	logic               verdict_valid;
	logic               verdict_stall = 1'b0;
	spct_pkg::verdict_t verdict;

	overlap_tracker     board = new();
	spct_pkg::pair_t    outgoing[$];
	int                 gap_pct = 0;
	int                 stall_pct = 0;
	int                 gap_left = 0;
	int                 hold_left = 0;
	bit                 long_hold_req = 1'b0;
	int                 cycle_count = 0;

	shape_pair_collision_test_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.pair_valid    (pair_valid),
		.pair_stall    (pair_stall),
		.pair          (pair),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict)
	);

	always #2 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Request side: offer the head of the outgoing queue, idle in bursts
	always @(posedge clk) begin
		if (pair_valid && !pair_stall) begin
			board.note_pair(pair);
			void'(outgoing.pop_front());
			if ($urandom_range(0, 99) < gap_pct)
				gap_left = $urandom_range(1, 15);
		end
		if (gap_left > 0) begin
			gap_left--;
			pair_valid <= 1'b0;
		end else if (outgoing.size() != 0 && arst_n) begin
			pair       <= outgoing[0];
			pair_valid <= 1'b1;
		end else begin
			pair_valid <= 1'b0;
		end
	end

	// Result side: check each verdict, stall in bursts or one long hold
	always @(posedge clk) begin
		if (arst_n && verdict_valid && !verdict_stall)
			board.check_verdict(verdict);
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end else if (hold_left == 0 && $urandom_range(0, 99) < stall_pct) begin
			hold_left = $urandom_range(1, 15);
		end
		if (hold_left > 0) begin
			hold_left--;
			verdict_stall <= 1'b1;
		end else begin
			verdict_stall <= 1'b0;
		end
	end

	function automatic spct_pkg::pair_t mk_pair(logic [1:0] t1, int x1, int y1, int w1,
			int h1, int r1, logic [1:0] t2, int x2, int y2, int w2, int h2, int r2);
		spct_pkg::pair_t p;
		p.first_type    = t1;
		p.first_x       = 16'(x1);
		p.first_y       = 16'(y1);
		p.first_width   = 15'(w1);
		p.first_height  = 15'(h1);
		p.first_radius  = 15'(r1);
		p.second_type   = t2;
		p.second_x      = 16'(x2);
		p.second_y      = 16'(y2);
		p.second_width  = 15'(w2);
		p.second_height = 15'(h2);
		p.second_radius = 15'(r2);
		return p;
	endfunction

	function automatic logic [1:0] rand_type();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 8)
			return spct_pkg::TYPE_BOX;
		else if (pick < 18)
			return spct_pkg::TYPE_CIRCLE;
		else
			return (pick == 18) ? TYPE_UNSUPPORTED : TYPE_RESERVED;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom_range(0, 2000)) - 16'd1000;
		endcase
	endfunction

	function automatic logic [14:0] rand_size();
		case ($urandom_range(0, 9))
			0: return 15'd0;
			1: return 15'h7fff;
			2, 3: return 15'($urandom_range(0, 32767));
			default: return 15'($urandom_range(1, 300));
		endcase
	endfunction

	// Mostly nearby shapes so both outcomes are common; some edge-aligned
	function automatic spct_pkg::pair_t random_pair();
		spct_pkg::pair_t p;
		p.first_type    = rand_type();
		p.first_x       = rand_coord();
		p.first_y       = rand_coord();
		p.first_width   = rand_size();
		p.first_height  = rand_size();
		p.first_radius  = rand_size();
		p.second_type   = rand_type();
		p.second_width  = rand_size();
		p.second_height = rand_size();
		p.second_radius = rand_size();
		if ($urandom_range(0, 9) < 7) begin
			p.second_x = p.first_x + 16'($urandom_range(0, 600)) - 16'd300;
			p.second_y = p.first_y + 16'($urandom_range(0, 600)) - 16'd300;
		end else begin
			p.second_x = rand_coord();
			p.second_y = rand_coord();
		end
		case ($urandom_range(0, 7))
			0: p.second_x = p.first_x + 16'(p.first_width);
			1: p.second_y = p.first_y + 16'(p.first_height);
			default: ;
		endcase
		return p;
	endfunction

	task automatic wait_sent();
		while (outgoing.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		wait_sent();
		while (board.expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic feed(int count);
		int n;
		for (n = 0; n < count; n++)
			outgoing.push_back(random_pair());
		wait_sent();
	endtask

	task automatic queue_directed();
		// box against box: overlap, shared edges, zero width
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0,
			spct_pkg::TYPE_BOX, 32, 32, 64, 64, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0,
			spct_pkg::TYPE_BOX, 64, 0, 64, 64, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0,
			spct_pkg::TYPE_BOX, 0, 64, 64, 64, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, 10, 0, 0, 64, 0,
			spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0));
		// circle against circle: overlap, exact touch, just apart
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 0, 0, 0, 0, 40,
			spct_pkg::TYPE_CIRCLE, 48, 64, 0, 0, 50));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 0, 0, 0, 0, 30,
			spct_pkg::TYPE_CIRCLE, 48, 64, 0, 0, 50));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 0, 0, 0, 0, 30,
			spct_pkg::TYPE_CIRCLE, 48, 64, 0, 0, 49));
		// circle against box: center within, corner touch and miss, swapped order
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 20, 20, 0, 0, 5,
			spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 112, 128, 0, 0, 80,
			spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 112, 128, 0, 0, 79,
			spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0,
			spct_pkg::TYPE_CIRCLE, 112, 128, 0, 0, 80));
		// zero radius on a box edge, on the other center; zero-size box
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 64, 30, 0, 0, 0,
			spct_pkg::TYPE_BOX, 0, 0, 64, 64, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, -5, -5, 0, 0, 0,
			spct_pkg::TYPE_CIRCLE, -5, -5, 0, 0, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, 100, 100, 0, 0, 0,
			spct_pkg::TYPE_CIRCLE, 100, 100, 0, 0, 0));
		// unsupported types on either side, even with overlapping geometry
		outgoing.push_back(mk_pair(TYPE_UNSUPPORTED, 0, 0, 64, 64, 9,
			spct_pkg::TYPE_BOX, 0, 0, 64, 64, 9));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 0, 0, 64, 64, 9,
			TYPE_RESERVED, 0, 0, 64, 64, 9));
		outgoing.push_back(mk_pair(TYPE_RESERVED, 0, 0, 0, 0, 0,
			TYPE_UNSUPPORTED, 0, 0, 0, 0, 0));
		// coordinate and size extremes
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, -32768, -32768, 32767, 32767, 0,
			spct_pkg::TYPE_BOX, 32767, 32767, 32767, 32767, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, -32768, -32768, 32767, 32767, 0,
			spct_pkg::TYPE_BOX, -1, -1, 32767, 32767, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_BOX, -32768, -32768, 32767, 32767, 0,
			spct_pkg::TYPE_BOX, -2, -2, 32767, 32767, 0));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, -32768, -32768, 0, 0, 32767,
			spct_pkg::TYPE_CIRCLE, 32767, 32767, 0, 0, 32767));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, -32768, 0, 0, 0, 32767,
			spct_pkg::TYPE_CIRCLE, 32766, 0, 0, 0, 32767));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, -32768, 0, 0, 0, 32767,
			spct_pkg::TYPE_CIRCLE, 32767, 0, 0, 0, 32767));
		outgoing.push_back(mk_pair(spct_pkg::TYPE_CIRCLE, 32767, 32767, 0, 0, 32767,
			spct_pkg::TYPE_BOX, -32768, -32768, 32767, 32767, 0));
	endtask

	// Test sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 25;
		stall_pct = 25;
		queue_directed();
		wait_sent();
		feed(600);

		// receiver never idles, sender does
		gap_pct   = 30;
		stall_pct = 0;
		feed(200);

		// long result hold while requests keep coming: pipeline fills
		gap_pct       = 0;
		long_hold_req = 1'b1;
		feed(40);

		// sender pauses until every verdict is back
		wait_drained();

		gap_pct   = 0;
		stall_pct = 20;
		feed(300);

		// closing stretch at full rate
		stall_pct = 0;
		feed(300);

		wait_drained();
		repeat (20) @(posedge clk);
		if (board.mismatch_count == 0 && board.expected_verdicts.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
